// File: hw/rtl/sspg_pkg.sv
// ----------------------------------------------------------------------------
// sspg_pkg
// Shared types and constants of the stepper step pulse generator.
// ----------------------------------------------------------------------------
package sspg_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 32;
  localparam int unsigned FIFO_DEPTH     = 2;

  localparam int unsigned SPEED_W   = 24;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned MS_W      = 32;
  localparam int unsigned SPR_W     = 16;
  localparam int unsigned HOLD_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 32;

  localparam int unsigned QUOT_W    = 32;
  localparam int unsigned DIVISOR_W = SPR_W + SPEED_W;
  localparam int unsigned QCNT_W    = $clog2(QUOT_W);

  // 360 * 16 * 500000: half period numerator in us
  localparam logic [QUOT_W-1:0] HP_NUM = 32'd2880000000;

  localparam logic [SPR_W-1:0]  SPR_RESET  = 16'd200;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd60000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIMEOUT_MS = 1'd1;

  localparam logic OP_SET_SPEED = 1'b0;
  localparam logic OP_TICK      = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SPEED_W-1:0]  speed_q4;
    logic [ELAPSED_W-1:0]       elapsed_us;
    logic                       set_reached;
    logic [MS_W-1:0]            ms_since_reached;
  } in_word_t;

  typedef struct packed {
    logic step_level;
    logic dir_level;
    logic enable_level;
    logic running;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_STOP = 2'd1,
    KIND_RUN  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                kind;
    logic                 neg;
    logic [SPEED_W-1:0]   mag;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 reached;
    logic                 hold_expired;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/sspg_fifo.sv
// ----------------------------------------------------------------------------
// sspg_fifo
// Small synchronous word queue with registered storage.
// ----------------------------------------------------------------------------
module sspg_fifo import sspg_pkg::*; #(
  parameter type         word_t = logic,
  parameter int unsigned DEPTH  = FIFO_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  word_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output word_t rdata_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  word_t              mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/sspg_front.sv
// ----------------------------------------------------------------------------
// sspg_front
// Accepts input words, classifies them and queues commands for the back end.
// ----------------------------------------------------------------------------
module sspg_front import sspg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  in_word_t          in_word_i,
  output logic              full,
  input  logic [HOLD_W-1:0] hold_timeout_i,
  input  logic              cmd_pop_i,
  output cmd_t              cmd_o,
  output logic              cmd_empty_o
);

  cmd_t cmd;

  always_comb begin
    cmd.neg          = in_word_i.speed_q4[SPEED_W-1];
    cmd.mag          = cmd.neg ? SPEED_W'(-in_word_i.speed_q4) : SPEED_W'(in_word_i.speed_q4);
    cmd.elapsed      = in_word_i.elapsed_us;
    cmd.reached      = in_word_i.set_reached;
    cmd.hold_expired = in_word_i.set_reached && (in_word_i.ms_since_reached > hold_timeout_i);
    if (in_word_i.op == OP_TICK) begin
      cmd.kind = KIND_TICK;
    end else if (in_word_i.speed_q4 == '0) begin
      cmd.kind = KIND_STOP;
    end else begin
      cmd.kind = KIND_RUN;
    end
  end

  sspg_fifo #(
    .word_t (cmd_t),
    .DEPTH  (FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cmd),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

// File: hw/rtl/sspg_div.sv
// ----------------------------------------------------------------------------
// sspg_div
// Restoring divider of the fixed half period numerator, one bit per cycle.
// ----------------------------------------------------------------------------
module sspg_div import sspg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output div_status_t          status_o,
  output logic [QUOT_W-1:0]    quot_o
);

  logic [DIVISOR_W-1:0] divisor_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [QUOT_W-1:0]    quot_q;
  logic [QCNT_W-1:0]    cnt_q;
  logic                 busy_q, done_q;
  logic [DIVISOR_W:0]   shifted;
  logic                 ge;

  assign shifted = {rem_q, HP_NUM[cnt_q]};
  assign ge      = (shifted >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= QCNT_W'(QUOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quot_q    <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? DIVISOR_W'(shifted - {1'b0, divisor_q}) : DIVISOR_W'(shifted);
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;

endmodule

// File: hw/rtl/sspg_back.sv
// ----------------------------------------------------------------------------
// sspg_back
// Executes queued commands: speed set-up, step timing and result queue.
// ----------------------------------------------------------------------------
module sspg_back import sspg_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SPR_W-1:0] steps_per_rev_i,
  input  cmd_t             cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  input  logic             pop,
  output logic             empty,
  output out_word_t        out_word_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_TICK   = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [TIME_WIDTH-1:0]  hp_q, hp_d, acc_q, acc_d;
  logic                   stopped_q, stopped_d, toggle_q, toggle_d;
  logic                   step_q, step_d, dir_q, dir_d, en_q, en_d;
  logic [DIVISOR_W-1:0]   prod_q, prod_d;

  logic                   div_start;
  div_status_t            div_sts;
  logic [QUOT_W-1:0]      quot;
  logic [QUOT_W+TIME_WIDTH-1:0] quot_x;
  logic [TIME_WIDTH-1:0]  hp_div;
  logic [TIME_WIDTH:0]    sum_wide;
  logic [TIME_WIDTH-1:0]  sum_sat, diff;

  logic                   out_push, out_full;
  out_word_t              res;

  assign quot_x   = {TIME_WIDTH'(0), quot};
  assign hp_div   = ((quot_x >> TIME_WIDTH) != '0) ? '1 : quot_x[TIME_WIDTH-1:0];
  assign sum_wide = {1'b0, acc_q} + (TIME_WIDTH + 1)'(cmd_i.elapsed);
  assign sum_sat  = sum_wide[TIME_WIDTH] ? '1 : sum_wide[TIME_WIDTH-1:0];
  assign diff     = acc_q - hp_q;

  always_comb begin
    state_d   = state_q;
    hp_d      = hp_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    toggle_d  = toggle_q;
    step_d    = step_q;
    dir_d     = dir_q;
    en_d      = en_q;
    prod_d    = prod_q;
    cmd_pop_o = 1'b0;
    out_push  = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i && !out_full) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            KIND_STOP: begin
              if (cmd_i.hold_expired) begin
                en_d = 1'b1;
              end
              stopped_d = 1'b1;
              out_push  = 1'b1;
            end
            KIND_RUN: begin
              if (!cmd_i.reached) begin
                en_d = 1'b0;
              end
              dir_d     = cmd_i.neg;
              stopped_d = 1'b0;
              prod_d    = DIVISOR_W'(steps_per_rev_i) * DIVISOR_W'(cmd_i.mag);
              state_d   = ST_LAUNCH;
            end
            KIND_TICK: begin
              if (stopped_q) begin
                out_push = 1'b1;
              end else begin
                acc_d   = sum_sat;
                state_d = ST_TICK;
              end
            end
            default: out_push = 1'b1;
          endcase
        end
      end
      ST_LAUNCH: begin
        if (prod_q == '0) begin
          hp_d     = '1;
          out_push = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_sts.done) begin
          hp_d     = hp_div;
          out_push = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (acc_q >= hp_q) begin
          step_d   = toggle_q;
          toggle_d = ~toggle_q;
          acc_d    = (diff > hp_q) ? '0 : diff;
        end
        out_push = 1'b1;
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hp_q      <= '0;
      acc_q     <= '0;
      stopped_q <= 1'b1;
      toggle_q  <= 1'b0;
      step_q    <= 1'b0;
      dir_q     <= 1'b0;
      en_q      <= 1'b1;
    end else begin
      state_q   <= state_d;
      hp_q      <= hp_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
      toggle_q  <= toggle_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
      en_q      <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  sspg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (prod_q),
    .status_o  (div_sts),
    .quot_o    (quot)
  );

  assign res.step_level   = step_d;
  assign res.dir_level    = dir_d;
  assign res.enable_level = en_d;
  assign res.running      = ~stopped_d;

  sspg_fifo #(
    .word_t (out_word_t),
    .DEPTH  (FIFO_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_word_o),
    .empty_o (empty)
  );

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("back end state not one-hot");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == ST_IDLE) else $error("command taken while busy");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full) else $error("result pushed into full queue");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> state_q == ST_DIV) else $error("divider done outside wait");

  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> div_sts.busy) else $error("divider did not start");
`endif

endmodule

// File: hw/rtl/stepper_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// stepper_step_pulse_generator
// Step, direction and enable level generator for a stepper driver.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word. A zero speed, or a tick while
// stopped, is handled in the idle state of the back end; a running tick also
// passes the tick state. A nonzero speed forms the steps-per-rev product; if
// that is not zero, the restoring divider forms the half period, one quotient
// bit per cycle. Two-word queues sit on the command and result sides, so
// input may be taken while a result waits to be popped.
module stepper_step_pulse_generator import sspg_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 push,
  input  in_word_t             in_word_i,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output out_word_t            out_word_o
);

  logic [SPR_W-1:0]  spr_q;
  logic [HOLD_W-1:0] hold_q;
  cmd_t              cmd;
  logic              cmd_empty, cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q  <= SPR_RESET;
      hold_q <= HOLD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEPS_PER_REV:   spr_q  <= cfg_data_i[SPR_W-1:0];
        CFG_HOLD_TIMEOUT_MS: hold_q <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  sspg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .in_word_i      (in_word_i),
    .full           (full),
    .hold_timeout_i (hold_q),
    .cmd_pop_i      (cmd_pop),
    .cmd_o          (cmd),
    .cmd_empty_o    (cmd_empty)
  );

  sspg_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .steps_per_rev_i (spr_q),
    .cmd_i           (cmd),
    .cmd_empty_i     (cmd_empty),
    .cmd_pop_o       (cmd_pop),
    .pop             (pop),
    .empty           (empty),
    .out_word_o      (out_word_o)
  );

endmodule
